// ----- hw/rtl/qghc_pkg.sv -----
// Shared widths and constants for the quad geometric hash code block.
`timescale 1ns / 1ps

package qghc_pkg;

    localparam int PT_W        = 24;   // input coordinate, 8 fractional bits
    localparam int DIFF_W      = 25;   // point minus A
    localparam int CS_W        = 26;   // dy + dx, dy - dx
    localparam int SQ_W        = 50;   // dx * dx
    localparam int PROD_W      = 51;   // difference times cos or sin term
    localparam int NUM_W       = 52;   // code numerator
    localparam int MAG_W       = 51;   // magnitude of numerator
    localparam int SCALE_W     = 50;   // squared base length, 16 fractional bits
    localparam int INT_BITS    = 7;    // integer quotient bits before saturation
    localparam int DIV_STEPS   = 32;   // quotient bits produced by the divider
    localparam int CODE_W      = 32;
    localparam int CFG_W       = 3;
    localparam int NUM_FIELDS  = 10;
    localparam int CODE_PTS    = 3;    // C, D, E
    localparam int IN_TDATA_W  = 240;
    localparam int OUT_TDATA_W = 248;
    localparam int MIN_POINTS  = 3;

    localparam logic [CFG_W-1:0]  POINTS_RESET = 3'd4;
    localparam logic [CODE_W-1:0] CODE_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [CODE_W-1:0] CODE_NEG_MAX = 32'h8000_0000;

    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [CS_W-1:0]   cs_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [NUM_W-1:0]  num_t;
    typedef logic [SCALE_W-1:0]       scale_t;
    typedef logic [CODE_W-1:0]        code_t;

endpackage

// ----- hw/rtl/quad_geometric_hash_code_top.sv -----
// Top level of the quad geometric hash code block: fully pipelined datapath.
`timescale 1ns / 1ps

// Takes one quad of up to five points per word and returns, per word, the
// hash codes of C, D and E relative to base AB, the squared base length and
// a degenerate flag. Throughput is one word per clock unless the output stalls;
// from input accept to output valid a word passes five arithmetic stages
// (differences, squares, products, sums, magnitude and saturation check), a
// 32-stage restoring divider that retires one quotient bit per stage, and a
// final rounding and output register. The divider chain sets the latency. The
// whole pipeline holds while an output word waits and m_tready is low;
// bubbles travel as cleared valid bits. points_in_quad is written through
// the cfg channel, which is always ready; write it only while no word is in
// flight. Codes of points beyond the count, and all codes of a degenerate
// base, come out as zero.
module quad_geometric_hash_code_top #(
    parameter int MAX_POINTS = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // cfg: points_in_quad[2:0]
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [qghc_pkg::CFG_W-1:0]        cfg_data,
    // s_tdata from bit 0: pt_a_x, pt_a_y, pt_b_x, pt_b_y, pt_c_x, pt_c_y,
    // pt_d_x, pt_d_y, pt_e_x, pt_e_y (24 bits each)
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [qghc_pkg::IN_TDATA_W-1:0]   s_tdata,
    // m_tdata from bit 0: code_c_x, code_c_y, code_d_x, code_d_y, code_e_x,
    // code_e_y (32 bits each), base_scale (50 bits), zero pad (6 bits)
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [qghc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // m_tuser: degenerate
    output logic                              m_tuser
);
    import qghc_pkg::*;

    localparam int NP = MAX_POINTS - 2;
    localparam int NL = 2 * NP;

    logic en;
    logic [CFG_W-1:0] points_reg;

    // stage 1: differences
    logic  v1_reg;
    diff_t dx_reg, dy_reg;
    diff_t px1_reg [0:NP-1];
    diff_t py1_reg [0:NP-1];
    // stage 2: squares, cos and sin terms
    logic  v2_reg;
    logic signed [SQ_W-1:0] sqx_reg, sqy_reg;
    cs_t   c_reg, s_reg;
    diff_t px2_reg [0:NP-1];
    diff_t py2_reg [0:NP-1];
    // stage 3: products, scale
    logic   v3_reg;
    scale_t scale3_reg;
    prod_t  pc_reg [0:NP-1];
    prod_t  ps_reg [0:NP-1];
    prod_t  qc_reg [0:NP-1];
    prod_t  qs_reg [0:NP-1];
    // stage 4: numerators
    logic   v4_reg;
    scale_t scale4_reg;
    num_t   num_reg [0:NL-1];
    // divider stages, index 0 loaded from the magnitude stage
    logic   dv_reg    [0:DIV_STEPS];
    scale_t den_reg   [0:DIV_STEPS];
    scale_t rem_reg   [0:DIV_STEPS][0:NL-1];
    scale_t rem_next  [1:DIV_STEPS][0:NL-1];
    code_t  quo_reg   [0:DIV_STEPS][0:NL-1];
    code_t  quo_next  [1:DIV_STEPS][0:NL-1];
    logic [INT_BITS-1:0] mlo_reg [0:DIV_STEPS][0:NL-1];
    logic   neg_reg   [0:DIV_STEPS][0:NL-1];
    logic   sat_reg   [0:DIV_STEPS][0:NL-1];
    // output register
    logic   out_valid_reg;
    code_t  code_reg  [0:NL-1];
    code_t  code_next [0:NL-1];
    scale_t scale_out_reg;
    logic   degen_reg;
    logic [CFG_W-1:0] n_clamp;

    // Advance everything unless a finished word waits at the output.
    assign en        = !out_valid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_reg <= POINTS_RESET;
        end
        else if (cfg_valid)
        begin
            points_reg <= cfg_data;
        end
    end

    // Valid chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            dv_reg[0] <= v4_reg;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                dv_reg[k] <= dv_reg[k-1];
            end
            out_valid_reg <= dv_reg[DIV_STEPS];
        end
    end

    // Front arithmetic stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= DIFF_W'($signed(s_tdata[2*PT_W +: PT_W]))
                    - DIFF_W'($signed(s_tdata[0 +: PT_W]));
            dy_reg <= DIFF_W'($signed(s_tdata[3*PT_W +: PT_W]))
                    - DIFF_W'($signed(s_tdata[PT_W +: PT_W]));
            for (int j = 0; j < NP; j++)
            begin
                px1_reg[j] <= DIFF_W'($signed(s_tdata[(2*j+4)*PT_W +: PT_W]))
                            - DIFF_W'($signed(s_tdata[0 +: PT_W]));
                py1_reg[j] <= DIFF_W'($signed(s_tdata[(2*j+5)*PT_W +: PT_W]))
                            - DIFF_W'($signed(s_tdata[PT_W +: PT_W]));
            end

            sqx_reg <= dx_reg * dx_reg;
            sqy_reg <= dy_reg * dy_reg;
            c_reg   <= CS_W'(dy_reg) + CS_W'(dx_reg);
            s_reg   <= CS_W'(dy_reg) - CS_W'(dx_reg);
            for (int j = 0; j < NP; j++)
            begin
                px2_reg[j] <= px1_reg[j];
                py2_reg[j] <= py1_reg[j];
            end

            scale3_reg <= scale_t'(sqx_reg) + scale_t'(sqy_reg);
            for (int j = 0; j < NP; j++)
            begin
                pc_reg[j] <= PROD_W'(px2_reg[j]) * PROD_W'(c_reg);
                ps_reg[j] <= PROD_W'(py2_reg[j]) * PROD_W'(s_reg);
                qc_reg[j] <= PROD_W'(py2_reg[j]) * PROD_W'(c_reg);
                qs_reg[j] <= PROD_W'(px2_reg[j]) * PROD_W'(s_reg);
            end

            scale4_reg <= scale3_reg;
            for (int j = 0; j < NP; j++)
            begin
                num_reg[2*j]   <= NUM_W'(pc_reg[j]) + NUM_W'(ps_reg[j]);
                num_reg[2*j+1] <= NUM_W'(qc_reg[j]) - NUM_W'(qs_reg[j]);
            end
        end
    end

    // Magnitude, saturation check and divider load.
    always_ff @(posedge clk)
    begin
        logic [MAG_W-1:0] mag;
        if (en)
        begin
            den_reg[0] <= scale4_reg;
            for (int l = 0; l < NL; l++)
            begin
                mag = num_reg[l][NUM_W-1] ? MAG_W'(-num_reg[l]) : MAG_W'(num_reg[l]);
                neg_reg[0][l] <= num_reg[l][NUM_W-1];
                sat_reg[0][l] <= {{(SCALE_W+INT_BITS-MAG_W){1'b0}}, mag}
                                 >= {scale4_reg, {INT_BITS{1'b0}}};
                rem_reg[0][l] <= SCALE_W'(mag >> INT_BITS);
                mlo_reg[0][l] <= mag[INT_BITS-1:0];
                quo_reg[0][l] <= '0;
            end
        end
    end

    // One restoring step per stage: shift in the next dividend bit, compare, subtract.
    always_comb
    begin
        logic [SCALE_W:0]     shifted;
        logic [INT_BITS-1:0]  mlo_sh;
        logic                 ge;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            for (int l = 0; l < NL; l++)
            begin
                mlo_sh  = INT_BITS'(mlo_reg[k][l] << k);
                shifted = {rem_reg[k][l], mlo_sh[INT_BITS-1]};
                ge      = shifted >= {1'b0, den_reg[k]};
                rem_next[k+1][l] = ge ? SCALE_W'(shifted - {1'b0, den_reg[k]})
                                      : shifted[SCALE_W-1:0];
                quo_next[k+1][l] = {quo_reg[k][l][CODE_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                den_reg[k] <= den_reg[k-1];
                for (int l = 0; l < NL; l++)
                begin
                    rem_reg[k][l] <= rem_next[k][l];
                    quo_reg[k][l] <= quo_next[k][l];
                    mlo_reg[k][l] <= mlo_reg[k-1][l];
                    neg_reg[k][l] <= neg_reg[k-1][l];
                    sat_reg[k][l] <= sat_reg[k-1][l];
                end
            end
        end
    end

    // Clamp the point count.
    always_comb
    begin
        if (points_reg < CFG_W'(MIN_POINTS))
        begin
            n_clamp = CFG_W'(MIN_POINTS);
        end
        else if (points_reg > CFG_W'(MAX_POINTS))
        begin
            n_clamp = CFG_W'(MAX_POINTS);
        end
        else
        begin
            n_clamp = points_reg;
        end
    end

    // Round half up on the magnitude, apply sign, saturate, zero unused and degenerate codes.
    always_comb
    begin
        logic [CODE_W:0]   rnd;
        logic [CODE_W-1:0] q;
        logic              degen;
        degen = den_reg[DIV_STEPS] == '0;
        for (int l = 0; l < NL; l++)
        begin
            rnd = {1'b0, quo_reg[DIV_STEPS][l]} + (CODE_W+1)'(1);
            q   = rnd[CODE_W:1];
            if (sat_reg[DIV_STEPS][l])
            begin
                code_next[l] = neg_reg[DIV_STEPS][l] ? CODE_NEG_MAX : CODE_POS_MAX;
            end
            else if (neg_reg[DIV_STEPS][l])
            begin
                code_next[l] = q[CODE_W-1] ? CODE_NEG_MAX : -q;
            end
            else
            begin
                code_next[l] = q[CODE_W-1] ? CODE_POS_MAX : q;
            end
            if (degen || (l / 2 + 2 >= int'(n_clamp)))
            begin
                code_next[l] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < NL; l++)
            begin
                code_reg[l] <= code_next[l];
            end
            scale_out_reg <= den_reg[DIV_STEPS];
            degen_reg     <= den_reg[DIV_STEPS] == '0;
        end
    end

    // Pack the output word; codes of points beyond MAX_POINTS stay zero.
    always_comb
    begin
        m_tdata = '0;
        for (int l = 0; l < 2 * CODE_PTS; l++)
        begin
            if (l < NL)
            begin
                m_tdata[l*CODE_W +: CODE_W] = code_reg[l];
            end
        end
        m_tdata[2*CODE_PTS*CODE_W +: SCALE_W] = scale_out_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = degen_reg;

    // An accepted word enters the first stage.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted word did not enter the pipeline");

    // A degenerate base reports zero scale and a zero code for C.
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> scale_out_reg == '0 && code_reg[0] == '0)
        else $error("degenerate word carries nonzero scale or code");

    // A stalled output holds its word.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed under stall");

    // The divider holds while the output stalls.
    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(den_reg[DIV_STEPS]))
        else $error("divider advanced during stall");

endmodule

// ----- sim/quad_geometric_hash_code_top_tb.sv -----
// Testbench for the quad geometric hash code block: streams quads, predicts codes, checks words.
`timescale 1ns / 1ps

module quad_geometric_hash_code_top_tb;
    import qghc_pkg::*;

    localparam int LATENCY = 38;
    localparam int MAX_POINTS_TB = 5;

    typedef struct {
        logic [IN_TDATA_W-1:0] pts;
    } quad_t;

    typedef struct {
        logic [CODE_W-1:0]  codes [6];
        logic [SCALE_W-1:0] scale;
        logic               degen;
    } hash_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic m_tuser;

    quad_t  pending_quads [$];
    hash_t  expected_hashes [$];
    logic [CFG_W-1:0] points_cfg;
    int     errors;
    int     send_gap;
    int     hold_off;
    bit     long_hold_req;

    quad_geometric_hash_code_top uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Rounded quotient num * 2^24 / den, ties away from zero, saturated to 32 bits.
    function automatic logic [CODE_W-1:0] rotate_divide(longint num, longint den);
        bit neg;
        logic [127:0] mag;
        logic [127:0] q;
        begin
            neg = num < 0;
            mag = neg ? -num : num;
            q = ((mag << 25) / den + 1) >> 1;
            if (neg)
                return (q >= 128'h8000_0000) ? CODE_NEG_MAX : code_t'(-q);
            return (q > 128'h7FFF_FFFF) ? CODE_POS_MAX : code_t'(q);
        end
    endfunction

    function automatic hash_t hash_quad(logic [IN_TDATA_W-1:0] pts, logic [CFG_W-1:0] cfg);
        hash_t h;
        longint crd [10];
        longint dx, dy, c, s, scl, px, py;
        int n;
        begin
            for (int k = 0; k < 10; k++)
                crd[k] = longint'($signed(pts[k*PT_W +: PT_W]));
            dx = crd[2] - crd[0];
            dy = crd[3] - crd[1];
            scl = dx * dx + dy * dy;
            c = dy + dx;
            s = dy - dx;
            n = (cfg < 3) ? 3 : (cfg > MAX_POINTS_TB) ? MAX_POINTS_TB : cfg;
            for (int k = 0; k < 6; k++)
                h.codes[k] = '0;
            if (scl != 0)
                for (int i = 2; i < n; i++)
                begin
                    px = crd[2*i] - crd[0];
                    py = crd[2*i+1] - crd[1];
                    h.codes[2*(i-2)]   = rotate_divide(px * c + py * s, scl);
                    h.codes[2*(i-2)+1] = rotate_divide(py * c - px * s, scl);
                end
            h.scale = scale_t'(scl);
            h.degen = (scl == 0);
            return h;
        end
    endfunction

    // Driver: present queued quads with random gaps; predict on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_hashes.push_back(hash_quad(s_tdata, points_cfg));
                void'(pending_quads.pop_front());
            end
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (s_tvalid && !s_tready)
                s_tvalid <= 1'b1;  // hold the word
            else if (pending_quads.size() > 0)
            begin
                if (s_tvalid && $urandom_range(0, 5) == 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                            : $urandom_range(0, 2);
                end
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_quads[0].pts;
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Monitor: compare each output word against the oldest prediction; drive m_tready.
    always @(posedge clk or negedge rst_n)
    begin
        hash_t exp_h;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_off <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_hashes.size() == 0)
                begin
                    $display("%0t: unexpected word %h", $time, m_tdata);
                    errors++;
                end
                else
                begin
                    exp_h = expected_hashes.pop_front();
                    for (int k = 0; k < 6; k++)
                        if (m_tdata[k*CODE_W +: CODE_W] !== exp_h.codes[k])
                        begin
                            $display("%0t: code %0d expected %h actual %h", $time, k,
                                     exp_h.codes[k], m_tdata[k*CODE_W +: CODE_W]);
                            errors++;
                        end
                    if (m_tdata[6*CODE_W +: SCALE_W] !== exp_h.scale)
                    begin
                        $display("%0t: scale expected %h actual %h", $time, exp_h.scale,
                                 m_tdata[6*CODE_W +: SCALE_W]);
                        errors++;
                    end
                    if (m_tuser !== exp_h.degen)
                    begin
                        $display("%0t: degenerate expected %b actual %b", $time,
                                 exp_h.degen, m_tuser);
                        errors++;
                    end
                end
            end
            // Stall: one long hold-off on request, otherwise short random gaps.
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                m_tready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req <= 1'b0;
                hold_off <= 200;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                hold_off <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                        : $urandom_range(0, 2);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic logic [PT_W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return PT_W'($urandom_range(0, 64) - 32);
            default: return PT_W'($urandom);
        endcase
    endfunction

    task automatic queue_quad(logic [PT_W-1:0] c [10]);
        quad_t q;
        begin
            for (int k = 0; k < 10; k++)
                q.pts[k*PT_W +: PT_W] = c[k];
            pending_quads.push_back(q);
        end
    endtask

    task automatic queue_random(int count);
        logic [PT_W-1:0] c [10];
        begin
            for (int j = 0; j < count; j++)
            begin
                for (int k = 0; k < 10; k++)
                    c[k] = rand_coord();
                if ($urandom_range(0, 15) == 0)
                begin
                    c[2] = c[0];  // degenerate base
                    c[3] = c[1];
                end
                else if ($urandom_range(0, 3) == 0)
                    for (int k = 2; k < 10; k++)
                        c[k] = c[k % 2] + PT_W'($urandom_range(0, 4096) - 2048);
                queue_quad(c);
            end
        end
    endtask

    // Drain: wait until every word is sent and checked, then let the pipe settle.
    task automatic drain();
        begin
            while (pending_quads.size() != 0 || s_tvalid || expected_hashes.size() != 0)
                @(posedge clk);
            repeat (LATENCY + 4) @(posedge clk);
        end
    endtask

    task automatic write_points(logic [CFG_W-1:0] value);
        begin
            cfg_valid <= 1'b1;
            cfg_data  <= value;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            points_cfg = value;
            cfg_valid <= 1'b0;
        end
    endtask

    initial
    begin
        logic [PT_W-1:0] c [10];
        errors = 0;
        long_hold_req = 1'b0;
        points_cfg = POINTS_RESET;
        cfg_valid = 1'b0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, degenerate base, unit base, huge codes.
        for (int k = 0; k < 10; k++) c[k] = '0;
        queue_quad(c);
        for (int k = 0; k < 10; k++) c[k] = (k % 2) ? 24'h800000 : 24'h7FFFFF;
        queue_quad(c);
        for (int k = 0; k < 10; k++) c[k] = (k % 3) ? 24'h7FFFFF : 24'h800000;
        queue_quad(c);
        c = '{24'h0, 24'h0, 24'h1, 24'h0, 24'h7FFFFF, 24'h800000,
              24'h800000, 24'h7FFFFF, 24'h100, 24'hFFFF00};
        queue_quad(c);
        c = '{24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h0, 24'h0,
              24'h7FFFFF, 24'h800000, 24'h1, 24'h1};
        queue_quad(c);
        c = '{24'h100, 24'h200, 24'h200, 24'h200, 24'h180, 24'h280,
              24'h000, 24'h000, 24'hFFFFFF, 24'h1};
        queue_quad(c);
        queue_random(4);
        drain();

        // Sweep the point count through all register values, extremes included.
        for (int v = 0; v < 8; v++)
        begin
            write_points(CFG_W'(v));
            queue_random(8);
            drain();
        end

        // Main random run with a long receiver stall to back up the pipeline.
        write_points(3'd5);
        queue_random(200);
        long_hold_req = 1'b1;
        drain();
        write_points(3'd3);
        queue_random(120);
        drain();
        write_points(3'd4);
        queue_random(140);
        drain();

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
